// ===== design/ifs_fern_point_generator_core_macros.svh =====
// Assertion shorthands for the core block that checks its own logic.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef IFS_FERN_POINT_GENERATOR_CORE_MACROS_SVH
`define IFS_FERN_POINT_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define FPG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fern point generator: same-cycle check failed");

// Next-cycle implication.
`define FPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fern point generator: next-cycle check failed");

`endif

// ===== design/fpg_pkg.sv =====
package fpg_pkg;

    localparam int COORD_W         = 24;
    localparam int COORD_FRAC_BITS = 18;
    localparam int COEF_W          = 16;
    localparam int COEF_FRAC_BITS  = 14;
    localparam int PCT_W           = 7;
    localparam int SCALE_W         = 13;
    localparam int PIX_W           = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 8;
    localparam int PAYLOAD_W = 2 * COORD_W + 2 * PIX_W + 1 + 2;
    localparam int M_TDATA_W = ((PAYLOAD_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        MAP_STEM,
        MAP_LEAFLET,
        MAP_LEFT,
        MAP_RIGHT
    } map_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STEM_THRESHOLD,
        REG_LEAFLET_THRESHOLD,
        REG_LEFT_THRESHOLD,
        REG_X_SCALE,
        REG_X_OFFSET,
        REG_Y_SCALE,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } cfg_reg_t;

    // One classified item travelling from the front end to the datapath.
    typedef struct packed {
        logic valid;
        map_t map;
    } map_item_t;

    // Linear coefficients of one map, in the order a b c d.
    typedef logic signed [COEF_W-1:0] coef_set_t [4];

    // Map coefficients in hundredths: a b c d e f.
    localparam int MAP_HUNDREDTHS [4][6] = '{
        '{  0,   0,   0,  16, 0,   0},
        '{ 85,   4,  -4,  85, 0, 160},
        '{ 20, -26,  23,  22, 0, 160},
        '{-15,  28,  26,  24, 0,  44}
    };

    // Hundredths to fixed point, nearest with halves away from zero.
    function automatic longint to_fixed(int h, int bits);
        longint mag;
        longint v;
        mag = (h < 0) ? longint'(-h) : longint'(h);
        v   = (mag * (longint'(1) << bits) + 64'sd50) / 100;
        return (h < 0) ? -v : v;
    endfunction

    function automatic coef_set_t coef_set(int m);
        coef_set_t c;
        for (int k = 0; k < 4; k++) begin
            c[k] = COEF_W'(to_fixed(MAP_HUNDREDTHS[m][k], COEF_FRAC_BITS));
        end
        return c;
    endfunction

    // Offset e (k = 4) or f (k = 5) of a map at coordinate precision.
    function automatic logic signed [COORD_W-1:0] coord_offset(int m, int k);
        return COORD_W'(to_fixed(MAP_HUNDREDTHS[m][k], COORD_FRAC_BITS));
    endfunction

endpackage

// ===== design/fpg_front.sv =====
module fpg_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fpg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [fpg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fpg_pkg::S_TDATA_W-1:0]        s_axis_tdata,   // [6:0] rand_pct
    output fpg_pkg::map_item_t                   item,
    input  logic                                 item_ready
);

    logic [fpg_pkg::PCT_W-1:0] stem_threshold_reg;
    logic [fpg_pkg::PCT_W-1:0] leaflet_threshold_reg;
    logic [fpg_pkg::PCT_W-1:0] left_threshold_reg;
    logic                      valid_reg;
    fpg_pkg::map_t             map_reg;
    fpg_pkg::map_t             map_next;
    logic [fpg_pkg::PCT_W-1:0] pct;
    logic                      load;

    assign pct           = s_axis_tdata[fpg_pkg::PCT_W-1:0];
    assign load          = !valid_reg || item_ready;
    assign s_axis_tready = load;
    assign item.valid    = valid_reg;
    assign item.map      = map_reg;

    // The thresholds are cumulative, so the first one that the value falls below wins.
    always_comb
    begin
        priority if (pct < stem_threshold_reg)
        begin
            map_next = fpg_pkg::MAP_STEM;
        end
        else if (pct < leaflet_threshold_reg)
        begin
            map_next = fpg_pkg::MAP_LEAFLET;
        end
        else if (pct < left_threshold_reg)
        begin
            map_next = fpg_pkg::MAP_LEFT;
        end
        else
        begin
            map_next = fpg_pkg::MAP_RIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stem_threshold_reg    <= fpg_pkg::PCT_W'(1);
            leaflet_threshold_reg <= fpg_pkg::PCT_W'(86);
            left_threshold_reg    <= fpg_pkg::PCT_W'(93);
            valid_reg             <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (fpg_pkg::cfg_reg_t'(cfg_addr))
                    fpg_pkg::REG_STEM_THRESHOLD:
                        stem_threshold_reg <= cfg_wdata[fpg_pkg::PCT_W-1:0];
                    fpg_pkg::REG_LEAFLET_THRESHOLD:
                        leaflet_threshold_reg <= cfg_wdata[fpg_pkg::PCT_W-1:0];
                    fpg_pkg::REG_LEFT_THRESHOLD:
                        left_threshold_reg <= cfg_wdata[fpg_pkg::PCT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (load)
            begin
                valid_reg <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && s_axis_tvalid)
        begin
            map_reg <= map_next;
        end
    end

endmodule

// ===== design/fpg_map_queue.sv =====
module fpg_map_queue #(
    parameter int DEPTH = fpg_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fpg_pkg::map_item_t push_item,
    output logic               push_ready,
    output fpg_pkg::map_item_t pop_item,
    input  logic               pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fpg_pkg::map_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;

    assign push_ready    = (count_reg != CNT_W'(DEPTH));
    assign push          = push_item.valid && push_ready;
    assign pop_item.valid = (count_reg != '0);
    assign pop_item.map   = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= advance(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= advance(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item.map;
        end
    end

endmodule

// ===== design/fpg_back.sv =====
module fpg_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fpg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [fpg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  fpg_pkg::map_item_t                   item,
    output logic                                 pop,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [23:0] point_x, [47:24] point_y, [63:48] pixel_col, [79:64] pixel_row,
    // [80] in_image, [82:81] map_used, rest zero
    output logic [fpg_pkg::M_TDATA_W-1:0]        m_axis_tdata
);

    localparam int COORD_W  = fpg_pkg::COORD_W;
    localparam int COEF_W   = fpg_pkg::COEF_W;
    localparam int CFB      = fpg_pkg::COEF_FRAC_BITS;
    localparam int XFB      = fpg_pkg::COORD_FRAC_BITS;
    localparam int SCALE_W  = fpg_pkg::SCALE_W;
    localparam int PIX_W    = fpg_pkg::PIX_W;
    localparam int PROD_W   = COORD_W + COEF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int SHIFT_W  = SUM_W - CFB;
    localparam int NEXT_W   = SHIFT_W + 1;
    localparam int PPROD_W  = COORD_W + SCALE_W + 1;
    localparam int PSUM_W   = PPROD_W + 1;
    localparam int TRUNC_W  = PSUM_W - XFB;
    localparam int PAD_W    = fpg_pkg::M_TDATA_W - fpg_pkg::PAYLOAD_W;

    localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(longint'(1) << (CFB - 1));
    localparam logic signed [NEXT_W-1:0] POS_MAX =
        NEXT_W'((longint'(1) << (COORD_W - 1)) - 1);
    localparam logic signed [NEXT_W-1:0] POS_MIN =
        NEXT_W'(-(longint'(1) << (COORD_W - 1)));

    localparam fpg_pkg::coef_set_t COEF_STEM    = fpg_pkg::coef_set(0);
    localparam fpg_pkg::coef_set_t COEF_LEAFLET = fpg_pkg::coef_set(1);
    localparam fpg_pkg::coef_set_t COEF_LEFT    = fpg_pkg::coef_set(2);
    localparam fpg_pkg::coef_set_t COEF_RIGHT   = fpg_pkg::coef_set(3);

    // Configuration
    logic [SCALE_W-1:0] x_scale_reg;
    logic [PIX_W-1:0]   x_offset_reg;
    logic [SCALE_W-1:0] y_scale_reg;
    logic [PIX_W-1:0]   image_width_reg;
    logic [PIX_W-1:0]   image_height_reg;

    // Recurrence: product stage, then accumulate and write back the point.
    logic                        p1_valid_reg;
    fpg_pkg::map_t               p1_map_reg;
    logic signed [PROD_W-1:0]    p1_ax_reg, p1_by_reg, p1_cx_reg, p1_dy_reg;
    logic signed [COORD_W-1:0]   pos_x_reg, pos_y_reg;
    logic signed [COORD_W-1:0]   pos_x_next, pos_y_next;

    logic                        p2_valid_reg;
    fpg_pkg::map_t               p2_map_reg;
    logic signed [COORD_W-1:0]   p2_x_reg, p2_y_reg;

    logic                        p3_valid_reg;
    fpg_pkg::map_t               p3_map_reg;
    logic signed [COORD_W-1:0]   p3_x_reg, p3_y_reg;
    logic signed [PPROD_W-1:0]   p3_col_prod_reg, p3_row_prod_reg;

    logic                        out_valid_reg;
    logic [fpg_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [fpg_pkg::M_TDATA_W-1:0] out_data_next;

    logic                        advance;
    logic signed [COEF_W-1:0]    coef_a, coef_b, coef_c, coef_d;
    logic signed [COORD_W-1:0]   off_e, off_f;
    logic signed [SUM_W-1:0]     sum_x, sum_y;
    logic signed [SHIFT_W-1:0]   shift_x, shift_y;
    logic signed [NEXT_W-1:0]    next_x, next_y;
    logic signed [PSUM_W-1:0]    val_col, val_row;
    logic signed [TRUNC_W-1:0]   trunc_col, trunc_row;
    logic [PIX_W-1:0]            pixel_col, pixel_row;
    logic                        in_image;

    // The whole pipeline moves together; it only holds while a result waits.
    assign advance       = !out_valid_reg || m_axis_tready;
    // A new item may start only once the previous one has written back its point.
    assign pop           = advance && item.valid && !p1_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        unique case (item.map)
            fpg_pkg::MAP_STEM:
            begin
                coef_a = COEF_STEM[0];
                coef_b = COEF_STEM[1];
                coef_c = COEF_STEM[2];
                coef_d = COEF_STEM[3];
            end
            fpg_pkg::MAP_LEAFLET:
            begin
                coef_a = COEF_LEAFLET[0];
                coef_b = COEF_LEAFLET[1];
                coef_c = COEF_LEAFLET[2];
                coef_d = COEF_LEAFLET[3];
            end
            fpg_pkg::MAP_LEFT:
            begin
                coef_a = COEF_LEFT[0];
                coef_b = COEF_LEFT[1];
                coef_c = COEF_LEFT[2];
                coef_d = COEF_LEFT[3];
            end
            default:
            begin
                coef_a = COEF_RIGHT[0];
                coef_b = COEF_RIGHT[1];
                coef_c = COEF_RIGHT[2];
                coef_d = COEF_RIGHT[3];
            end
        endcase
    end

    always_comb
    begin
        unique case (p1_map_reg)
            fpg_pkg::MAP_STEM:
            begin
                off_e = fpg_pkg::coord_offset(0, 4);
                off_f = fpg_pkg::coord_offset(0, 5);
            end
            fpg_pkg::MAP_LEAFLET:
            begin
                off_e = fpg_pkg::coord_offset(1, 4);
                off_f = fpg_pkg::coord_offset(1, 5);
            end
            fpg_pkg::MAP_LEFT:
            begin
                off_e = fpg_pkg::coord_offset(2, 4);
                off_f = fpg_pkg::coord_offset(2, 5);
            end
            default:
            begin
                off_e = fpg_pkg::coord_offset(3, 4);
                off_f = fpg_pkg::coord_offset(3, 5);
            end
        endcase
    end

    function automatic logic signed [COORD_W-1:0] saturate(logic signed [NEXT_W-1:0] v);
        if (v > POS_MAX)
        begin
            return POS_MAX[COORD_W-1:0];
        end
        else if (v < POS_MIN)
        begin
            return POS_MIN[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] clamp_pix(logic signed [TRUNC_W-1:0] t);
        if (t[TRUNC_W-1])
        begin
            return '0;
        end
        else if (|t[TRUNC_W-2:PIX_W])
        begin
            return '1;
        end
        return t[PIX_W-1:0];
    endfunction

    // Round to nearest with halves up: add half an LSB, then an arithmetic shift floors.
    always_comb
    begin
        sum_x      = SUM_W'(p1_ax_reg) + SUM_W'(p1_by_reg) + ROUND_HALF;
        sum_y      = SUM_W'(p1_cx_reg) + SUM_W'(p1_dy_reg) + ROUND_HALF;
        shift_x    = sum_x[SUM_W-1:CFB];
        shift_y    = sum_y[SUM_W-1:CFB];
        next_x     = NEXT_W'(shift_x) + NEXT_W'(off_e);
        next_y     = NEXT_W'(shift_y) + NEXT_W'(off_f);
        pos_x_next = saturate(next_x);
        pos_y_next = saturate(next_y);
    end

    // Truncation toward zero is the floor plus one for a negative value with a fraction.
    always_comb
    begin
        val_col   = PSUM_W'(p3_col_prod_reg)
                    + $signed(PSUM_W'({x_offset_reg, {XFB{1'b0}}}));
        val_row   = PSUM_W'(p3_row_prod_reg);
        trunc_col = val_col[PSUM_W-1:XFB]
                    + {{(TRUNC_W-1){1'b0}}, val_col[PSUM_W-1] && (|val_col[XFB-1:0])};
        trunc_row = val_row[PSUM_W-1:XFB]
                    + {{(TRUNC_W-1){1'b0}}, val_row[PSUM_W-1] && (|val_row[XFB-1:0])};
        pixel_col = clamp_pix(trunc_col);
        pixel_row = clamp_pix(trunc_row);
        in_image  = !trunc_col[TRUNC_W-1]
                    && (trunc_col[TRUNC_W-2:0] < (TRUNC_W-1)'(image_width_reg))
                    && !trunc_row[TRUNC_W-1]
                    && (trunc_row[TRUNC_W-2:0] < (TRUNC_W-1)'(image_height_reg));
        out_data_next = {{PAD_W{1'b0}}, p3_map_reg, in_image, pixel_row, pixel_col,
                         p3_y_reg, p3_x_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg      <= SCALE_W'(500);
            x_offset_reg     <= PIX_W'(2500);
            y_scale_reg      <= SCALE_W'(500);
            image_width_reg  <= PIX_W'(5000);
            image_height_reg <= PIX_W'(5000);
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
            p3_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (fpg_pkg::cfg_reg_t'(cfg_addr))
                    fpg_pkg::REG_X_SCALE:      x_scale_reg      <= cfg_wdata[SCALE_W-1:0];
                    fpg_pkg::REG_X_OFFSET:     x_offset_reg     <= cfg_wdata[PIX_W-1:0];
                    fpg_pkg::REG_Y_SCALE:      y_scale_reg      <= cfg_wdata[SCALE_W-1:0];
                    fpg_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[PIX_W-1:0];
                    fpg_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[PIX_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (advance)
            begin
                p1_valid_reg  <= pop;
                p2_valid_reg  <= p1_valid_reg;
                p3_valid_reg  <= p2_valid_reg;
                out_valid_reg <= p3_valid_reg;
                if (p1_valid_reg)
                begin
                    pos_x_reg <= pos_x_next;
                    pos_y_reg <= pos_y_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (pop)
            begin
                p1_map_reg <= item.map;
                p1_ax_reg  <= PROD_W'(coef_a) * PROD_W'(pos_x_reg);
                p1_by_reg  <= PROD_W'(coef_b) * PROD_W'(pos_y_reg);
                p1_cx_reg  <= PROD_W'(coef_c) * PROD_W'(pos_x_reg);
                p1_dy_reg  <= PROD_W'(coef_d) * PROD_W'(pos_y_reg);
            end
            p2_map_reg      <= p1_map_reg;
            p2_x_reg        <= pos_x_next;
            p2_y_reg        <= pos_y_next;
            p3_map_reg      <= p2_map_reg;
            p3_x_reg        <= p2_x_reg;
            p3_y_reg        <= p2_y_reg;
            p3_col_prod_reg <= PPROD_W'(p2_x_reg) * PPROD_W'($signed({1'b0, x_scale_reg}));
            p3_row_prod_reg <= PPROD_W'(p2_y_reg) * PPROD_W'($signed({1'b0, y_scale_reg}));
            out_data_reg    <= out_data_next;
        end
    end

endmodule

// ===== design/ifs_fern_point_generator_core.sv =====
// An accepted input passes the front register, the map queue and the product, point,
// pixel-product and output registers to m_axis_tvalid. A new item starts only once the
// previous one has written back its point; a two-entry queue decouples input and output.
// Reset (rst_n low, asynchronous): the point returns to the origin, the configuration
// registers take their default values and all pipeline and queue contents are dropped.
module ifs_fern_point_generator_core #(
    parameter int QUEUE_DEPTH = fpg_pkg::QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fpg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [fpg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fpg_pkg::S_TDATA_W-1:0]        s_axis_tdata,   // [6:0] rand_pct
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [23:0] point_x, [47:24] point_y, [63:48] pixel_col, [79:64] pixel_row,
    // [80] in_image, [82:81] map_used, rest zero
    output logic [fpg_pkg::M_TDATA_W-1:0]        m_axis_tdata
);

    `include "ifs_fern_point_generator_core_macros.svh"

    fpg_pkg::map_item_t front_item;
    fpg_pkg::map_item_t q_item;
    logic               front_ready;
    logic               back_pop;

    fpg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .item          (front_item),
        .item_ready    (front_ready)
    );

    fpg_map_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_ready (front_ready),
        .pop_item   (q_item),
        .pop        (back_pop)
    );

    fpg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .item          (q_item),
        .pop           (back_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `FPG_ASSERT_IMPL(a_pop_needs_item, back_pop, q_item.valid)
    `FPG_ASSERT_NEXT(a_queue_keeps_item, q_item.valid && !back_pop, q_item.valid)
    `FPG_ASSERT_NEXT(a_front_holds_item, front_item.valid && !front_ready,
                     front_item.valid && $stable(front_item.map))

endmodule

// ===== tb/sv/ifs_fern_point_generator_core_tb.sv =====
`timescale 1ns / 100ps

module ifs_fern_point_generator_core_tb;

    import fpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 250;

    // Bit positions of the result fields in m_axis_tdata.
    localparam int POS_Y   = COORD_W;
    localparam int POS_COL = 2 * COORD_W;
    localparam int POS_ROW = POS_COL + PIX_W;
    localparam int POS_IN  = POS_ROW + PIX_W;
    localparam int POS_MAP = POS_IN + 1;
    localparam int POS_PAD = POS_MAP + 2;
    localparam int PAD_W   = M_TDATA_W - POS_PAD;

    localparam longint COORD_MAX = 64'sd8388607;
    localparam longint COORD_MIN = -64'sd8388608;

    // Linear terms a b c d of each map in Q2.14, rounded to nearest.
    localparam longint MAP_COEF [4][4] = '{
        '{    0,     0,    0,  2621},
        '{13926,   655, -655, 13926},
        '{ 3277, -4260, 3768,  3604},
        '{-2458,  4588, 4260,  3932}
    };

    // Offsets e f of each map in Q6.18.
    localparam longint MAP_OFFSET [4][2] = '{
        '{0,      0},
        '{0, 419430},
        '{0, 419430},
        '{0, 115343}
    };

    typedef enum {
        CFG_TYPICAL,
        CFG_RANDOM,
        CFG_SKEWED,
        CFG_ZERO,
        CFG_ONES
    } cfg_style_t;

    localparam int RESET_PCTS [12] = '{0, 1, 2, 84, 85, 86, 92, 93, 98, 99, 100, 127};
    localparam int SKEWED_PCTS [6] = '{0, 59, 60, 99, 126, 127};
    localparam int ZERO_PCTS [3]   = '{0, 64, 127};

    localparam cfg_style_t PHASE_STYLE [RANDOM_PHASES] = '{
        CFG_TYPICAL, CFG_RANDOM, CFG_TYPICAL, CFG_ONES,
        CFG_TYPICAL, CFG_SKEWED, CFG_TYPICAL, CFG_RANDOM
    };

    typedef struct {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [PIX_W-1:0]          pixel_col;
        logic [PIX_W-1:0]          pixel_row;
        logic                      in_image;
        map_t                      map_used;
    } fern_point_t;

    class fern_scoreboard;
        logic [PCT_W-1:0]   stem_thr;
        logic [PCT_W-1:0]   leaflet_thr;
        logic [PCT_W-1:0]   left_thr;
        logic [SCALE_W-1:0] x_scale;
        logic [SCALE_W-1:0] y_scale;
        logic [PIX_W-1:0]   x_offset;
        logic [PIX_W-1:0]   image_w;
        logic [PIX_W-1:0]   image_h;
        longint             pos_x;
        longint             pos_y;
        fern_point_t        pending_points[$];
        int                 errors;
        int                 points_checked;
        int                 inside_count;
        int                 map_count[4];

        function new();
            stem_thr       = 7'd1;
            leaflet_thr    = 7'd86;
            left_thr       = 7'd93;
            x_scale        = 13'd500;
            x_offset       = 16'd2500;
            y_scale        = 13'd500;
            image_w        = 16'd5000;
            image_h        = 16'd5000;
            pos_x          = 0;
            pos_y          = 0;
            errors         = 0;
            points_checked = 0;
            inside_count   = 0;
            foreach (map_count[i])
                map_count[i] = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_STEM_THRESHOLD:    stem_thr    = v[PCT_W-1:0];
                REG_LEAFLET_THRESHOLD: leaflet_thr = v[PCT_W-1:0];
                REG_LEFT_THRESHOLD:    left_thr    = v[PCT_W-1:0];
                REG_X_SCALE:           x_scale     = v[SCALE_W-1:0];
                REG_X_OFFSET:          x_offset    = v[PIX_W-1:0];
                REG_Y_SCALE:           y_scale     = v[SCALE_W-1:0];
                REG_IMAGE_WIDTH:       image_w     = v[PIX_W-1:0];
                REG_IMAGE_HEIGHT:      image_h     = v[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip_coord(longint v);
            if (v > COORD_MAX)
                return COORD_MAX;
            if (v < COORD_MIN)
                return COORD_MIN;
            return v;
        endfunction

        // Drops the coordinate fraction, rounding toward zero.
        function longint pixel_trunc(longint v);
            if (v < 0)
                return -((-v) >>> COORD_FRAC_BITS);
            return v >>> COORD_FRAC_BITS;
        endfunction

        function logic [PIX_W-1:0] pixel_clamp(longint t);
            if (t < 0)
                return '0;
            if (t > 65535)
                return '1;
            return t[PIX_W-1:0];
        endfunction

        // Advances the stored point by one step and queues the resulting point.
        function void note_input(logic [PCT_W-1:0] pct);
            map_t        m;
            int          k;
            longint      sx;
            longint      sy;
            longint      tc;
            longint      tr;
            fern_point_t p;

            if (pct < stem_thr)
                m = MAP_STEM;
            else if (pct < leaflet_thr)
                m = MAP_LEAFLET;
            else if (pct < left_thr)
                m = MAP_LEFT;
            else
                m = MAP_RIGHT;
            k = int'(m);

            // Exact sum of products, rounded half up to coordinate precision.
            sx = MAP_COEF[k][0] * pos_x + MAP_COEF[k][1] * pos_y
                 + (longint'(1) << (COEF_FRAC_BITS - 1));
            sy = MAP_COEF[k][2] * pos_x + MAP_COEF[k][3] * pos_y
                 + (longint'(1) << (COEF_FRAC_BITS - 1));
            pos_x = clip_coord((sx >>> COEF_FRAC_BITS) + MAP_OFFSET[k][0]);
            pos_y = clip_coord((sy >>> COEF_FRAC_BITS) + MAP_OFFSET[k][1]);

            tc = pixel_trunc(pos_x * longint'(x_scale)
                             + (longint'(x_offset) << COORD_FRAC_BITS));
            tr = pixel_trunc(pos_y * longint'(y_scale));

            p.point_x   = pos_x[COORD_W-1:0];
            p.point_y   = pos_y[COORD_W-1:0];
            p.pixel_col = pixel_clamp(tc);
            p.pixel_row = pixel_clamp(tr);
            p.in_image  = (tc >= 0) && (tc < longint'(image_w)) &&
                          (tr >= 0) && (tr < longint'(image_h));
            p.map_used  = m;
            pending_points.push_back(p);
            map_count[k]++;
            if (p.in_image)
                inside_count++;
        endfunction

        function void compare_field(string name, logic signed [31:0] exp_v,
                                    logic signed [31:0] act_v);
            if (act_v !== exp_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            fern_point_t e;

            if (pending_points.size() == 0)
            begin
                errors++;
                $display("%0t: point with none expected, expected nothing, got tdata %h",
                         $time, d);
                return;
            end
            e = pending_points.pop_front();
            points_checked++;
            compare_field("point_x", 32'(e.point_x), 32'($signed(d[0 +: COORD_W])));
            compare_field("point_y", 32'(e.point_y), 32'($signed(d[POS_Y +: COORD_W])));
            compare_field("pixel_col", {16'b0, e.pixel_col}, {16'b0, d[POS_COL +: PIX_W]});
            compare_field("pixel_row", {16'b0, e.pixel_row}, {16'b0, d[POS_ROW +: PIX_W]});
            compare_field("in_image", {31'b0, e.in_image}, {31'b0, d[POS_IN]});
            compare_field("map_used", {30'b0, e.map_used}, {30'b0, d[POS_MAP +: 2]});
            compare_field("padding", 32'sd0, {{(32 - PAD_W){1'b0}}, d[M_TDATA_W-1:POS_PAD]});
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    fern_scoreboard fern_sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int configs_loaded = 0;
    int quiet_cycles   = 0;

    ifs_fern_point_generator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            fern_sb.check_result(m_axis_tdata);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Holds tvalid high across back-to-back items; it only drops for a gap.
    task automatic send_pct(logic [PCT_W-1:0] pct);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - PCT_W){1'b0}}, pct};
        do
            @(posedge clk);
        while (!s_axis_tready);
        fern_sb.note_input(pct);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (fern_sb.pending_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        fern_sb.write_reg(idx, v);
    endtask

    task automatic load_config(cfg_style_t style);
        logic [CFG_DATA_W-1:0] v [8];
        logic [CFG_DATA_W-1:0] tmp;

        case (style)
            CFG_TYPICAL:
            begin
                v[0] = CFG_DATA_W'($urandom_range(0, 100));
                v[1] = CFG_DATA_W'($urandom_range(0, 100));
                v[2] = CFG_DATA_W'($urandom_range(0, 100));
                // Sort the three thresholds into ascending order.
                if (v[0] > v[1]) begin tmp = v[0]; v[0] = v[1]; v[1] = tmp; end
                if (v[1] > v[2]) begin tmp = v[1]; v[1] = v[2]; v[2] = tmp; end
                if (v[0] > v[1]) begin tmp = v[0]; v[0] = v[1]; v[1] = tmp; end
                v[3] = CFG_DATA_W'($urandom_range(1, 1200));
                v[4] = CFG_DATA_W'($urandom_range(0, 5000));
                v[5] = CFG_DATA_W'($urandom_range(1, 1200));
                v[6] = CFG_DATA_W'($urandom_range(0, 6000));
                v[7] = CFG_DATA_W'($urandom_range(0, 6000));
            end
            CFG_RANDOM:
                foreach (v[i])
                    v[i] = CFG_DATA_W'($urandom);
            CFG_SKEWED:
            begin
                // Thresholds out of order, largest scales and offset, 1x1 image.
                v[0] = 16'd60;
                v[1] = 16'd20;
                v[2] = 16'd127;
                v[3] = 16'd8191;
                v[4] = 16'd65535;
                v[5] = 16'd8191;
                v[6] = 16'd1;
                v[7] = 16'd1;
            end
            CFG_ZERO:
                foreach (v[i])
                    v[i] = '0;
            default:
                foreach (v[i])
                    v[i] = '1;
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(cfg_reg_t'(i), v[i]);
        cfg_we <= 1'b0;
        configs_loaded++;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
            3:       begin send_idle_pct = 23; recv_stall_pct = 23; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items, starting from the reset register values.
        set_idling(0);
        foreach (RESET_PCTS[i])
            send_pct(PCT_W'(RESET_PCTS[i]));
        wait_idle();
        load_config(CFG_SKEWED);
        foreach (SKEWED_PCTS[i])
            send_pct(PCT_W'(SKEWED_PCTS[i]));
        wait_idle();
        load_config(CFG_ZERO);
        foreach (ZERO_PCTS[i])
            send_pct(PCT_W'(ZERO_PCTS[i]));

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            load_config(PHASE_STYLE[ph]);
            set_idling(ph % 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Mostly legal percents, with some values above 99.
                if ($urandom_range(0, 9) == 0)
                    send_pct(PCT_W'($urandom_range(100, 127)));
                else
                    send_pct(PCT_W'($urandom_range(0, 99)));
            end
        end
        wait_idle();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Checked %0d fern points from %0d input transactions",
                 fern_sb.points_checked, items_sent);
        $display("under %0d register settings; maps stem %0d, leaflet %0d, left %0d, right %0d.",
                 configs_loaded + 1, fern_sb.map_count[0], fern_sb.map_count[1],
                 fern_sb.map_count[2], fern_sb.map_count[3]);
        if (fern_sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
